// ===== design/assert_macros.svh =====
// assertion macros shared by the arithmetic unit rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds in a cycle, cons holds in the same cycle
`define CRAU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

// ante holds in a cycle, cons holds in the next cycle
`define CRAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

// ===== design/crau_pkg.sv =====
// types and codes for the complex/real arithmetic unit
// no dependencies
package crau_pkg;

    localparam int FIELD_W = 32;

    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_NEG  = 4'd2;
    localparam logic [3:0] OP_MUL  = 4'd3;
    localparam logic [3:0] OP_MULJ = 4'd4;
    localparam logic [3:0] OP_DIV  = 4'd5;
    localparam logic [3:0] OP_NOT  = 4'd6;
    localparam logic [3:0] OP_OR   = 4'd7;
    localparam logic [3:0] OP_AND  = 4'd8;
    localparam logic [3:0] OP_EQ   = 4'd9;
    localparam logic [3:0] OP_NE   = 4'd10;
    localparam logic [3:0] OP_GT   = 4'd11;
    localparam logic [3:0] OP_LT   = 4'd12;
    localparam logic [3:0] OP_GE   = 4'd13;
    localparam logic [3:0] OP_LE   = 4'd14;

    localparam logic [1:0] KIND_REAL    = 2'd0;
    localparam logic [1:0] KIND_COMPLEX = 2'd1;
    localparam logic [1:0] KIND_BOOL    = 2'd2;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_KIND = 2'd1;
    localparam logic [1:0] ERR_CPLX = 2'd2;
    localparam logic [1:0] ERR_DIV0 = 2'd3;

    typedef struct packed {
        logic [3:0]                req_type;
        logic [1:0]                left_kind;
        logic signed [FIELD_W-1:0] left_re;
        logic signed [FIELD_W-1:0] left_im;
        logic [1:0]                right_kind;
        logic signed [FIELD_W-1:0] right_real;
        logic signed [FIELD_W-1:0] right_imag;
    } req_t;

    typedef struct packed {
        logic [1:0]                result_kind;
        logic signed [FIELD_W-1:0] result_real;
        logic signed [FIELD_W-1:0] result_imag;
        logic [1:0]                error_code;
        logic                      saturated;
    } result_t;

endpackage

// ===== design/crau_div.sv =====
// pipelined restoring divider: q = floor(num * 2^FB / den), one quotient bit per stage
// standalone, no package use; one item per cycle
module crau_div #(
    parameter int DW = 32,
    parameter int FB = 16
) (
    input  logic            clk,
    input  logic [2*DW-1:0] num,
    input  logic [2*DW-1:0] den,
    input  logic            neg,
    output logic [DW-1:0]   q,
    output logic            ovf,
    output logic            neg_out
);

    localparam int PW = 2 * DW;
    localparam int NW = 2 * DW + FB;
    localparam int RW = 2 * DW + 1;
    localparam int CW = 3 * DW + FB;

    logic [NW-1:0] nfull;
    logic          ovf_in;

    logic [RW-1:0] r_reg   [DW+1];
    logic [DW-1:0] lo_reg  [DW+1];
    logic [DW-1:0] q_reg   [DW+1];
    logic [PW-1:0] d_reg   [DW+1];
    logic          ovf_reg [DW+1];
    logic          neg_reg [DW+1];

    assign nfull  = NW'(num) << FB;
    // quotient does not fit in DW bits
    assign ovf_in = CW'(nfull) >= (CW'(den) << DW);

    always_ff @(posedge clk)
    begin
        r_reg[0]   <= RW'(nfull >> DW);
        lo_reg[0]  <= nfull[DW-1:0];
        q_reg[0]   <= '0;
        d_reg[0]   <= den;
        ovf_reg[0] <= ovf_in;
        neg_reg[0] <= neg;
    end

    for (genvar k = 0; k < DW; k++)
    begin : g_step
        logic [RW-1:0] trial;
        logic          ge;

        assign trial = {r_reg[k][RW-2:0], lo_reg[k][DW-1]};
        assign ge    = trial >= {1'b0, d_reg[k]};

        always_ff @(posedge clk)
        begin
            r_reg[k+1]   <= ge ? trial - {1'b0, d_reg[k]} : trial;
            lo_reg[k+1]  <= lo_reg[k] << 1;
            q_reg[k+1]   <= {q_reg[k][DW-2:0], ge};
            d_reg[k+1]   <= d_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
            neg_reg[k+1] <= neg_reg[k];
        end
    end

    assign q       = q_reg[DW];
    assign ovf     = ovf_reg[DW];
    assign neg_out = neg_reg[DW];

endmodule

// ===== design/complex_real_arithmetic_unit_core.sv =====
// top level of the complex/real arithmetic unit
// depends on crau_pkg, crau_div and assert_macros.svh
//
// Takes one item per clock whenever start is high; busy never rises. Every item,
// whatever its opcode, comes out as a one-cycle done strobe with the result, in
// order. The path runs through decode, multiply and sum registers, the divider
// setup register, one quotient bit per pipeline stage for DW stages, and the
// output register. The result must be taken in the cycle done is high.
module complex_real_arithmetic_unit_core #(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  crau_pkg::req_t  req,
    output logic            done,
    output crau_pkg::result_t result
);

`include "assert_macros.svh"

    localparam int DW  = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
    localparam int FB  = (FRACTION_BITS > 31) ? 31 : FRACTION_BITS;
    localparam int PW  = 2 * DW;
    localparam int SW  = 2 * DW + 1;
    localparam int DL  = DW + 1;
    localparam int LAT = DW + 5;

    localparam logic [2:0] SEL_ADD  = 3'd0;
    localparam logic [2:0] SEL_SUB  = 3'd1;
    localparam logic [2:0] SEL_NEG  = 3'd2;
    localparam logic [2:0] SEL_MUL  = 3'd3;
    localparam logic [2:0] SEL_MULJ = 3'd4;
    localparam logic [2:0] SEL_DIVR = 3'd5;
    localparam logic [2:0] SEL_DIVC = 3'd6;
    localparam logic [2:0] SEL_BOOL = 3'd7;

    localparam logic signed [SW-1:0] SAT_HI = SW'((65'sd1 <<< (DW - 1)) - 65'sd1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);
    localparam logic signed [DW-1:0] MAXV   = DW'(SAT_HI);
    localparam logic signed [DW-1:0] MINV   = DW'(SAT_LO);

    typedef struct packed {
        logic [2:0] sel;
        logic [1:0] err;
        logic [1:0] kind;
        logic       bval;
    } ctl_t;

    typedef struct packed {
        ctl_t                   ctl;
        logic signed [DW-1:0]   re;
        logic signed [DW-1:0]   im;
        logic                   sat;
    } line_t;

    function automatic logic signed [DW-1:0] clamp(input logic signed [SW-1:0] x);
        if (x > SAT_HI)
            return MAXV;
        else if (x < SAT_LO)
            return MINV;
        return DW'(x);
    endfunction

    function automatic logic clipped(input logic signed [SW-1:0] x);
        return (x > SAT_HI) || (x < SAT_LO);
    endfunction

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] x);
        return x[DW-1] ? DW'(-x) : DW'(x);
    endfunction

    // ---------------- stage 1: decode ----------------
    ctl_t                 ctl1_next;
    logic signed [DW-1:0] a_in, b_in, c_in, d_in;
    logic                 lnum, rnum, lok, rok, tl, tr;
    logic [1:0]           lk, rk;

    logic                 v1_reg;
    ctl_t                 ctl1_reg;
    logic signed [DW-1:0] a1_reg, b1_reg, c1_reg, d1_reg;

    assign lk   = req.left_kind;
    assign rk   = req.right_kind;
    assign a_in = req.left_re[DW-1:0];
    assign b_in = (lk == crau_pkg::KIND_COMPLEX) ? req.left_im[DW-1:0] : '0;
    assign c_in = req.right_real[DW-1:0];
    assign d_in = (rk == crau_pkg::KIND_COMPLEX) ? req.right_imag[DW-1:0] : '0;
    assign lnum = (lk == crau_pkg::KIND_REAL) || (lk == crau_pkg::KIND_COMPLEX);
    assign rnum = (rk == crau_pkg::KIND_REAL) || (rk == crau_pkg::KIND_COMPLEX);
    assign lok  = lnum || (lk == crau_pkg::KIND_BOOL);
    assign rok  = rnum || (rk == crau_pkg::KIND_BOOL);
    assign tl   = (a_in != '0) || (b_in != '0);
    assign tr   = (c_in != '0) || (d_in != '0);

    always_comb
    begin
        ctl1_next.sel  = SEL_BOOL;
        ctl1_next.err  = crau_pkg::ERR_NONE;
        ctl1_next.kind = crau_pkg::KIND_BOOL;
        ctl1_next.bval = 1'b0;
        unique case (req.req_type)
            crau_pkg::OP_ADD, crau_pkg::OP_SUB, crau_pkg::OP_MUL:
            begin
                if (!(lnum && rnum))
                    ctl1_next.err = crau_pkg::ERR_KIND;
                else
                begin
                    ctl1_next.sel = (req.req_type == crau_pkg::OP_ADD) ? SEL_ADD :
                                    (req.req_type == crau_pkg::OP_SUB) ? SEL_SUB : SEL_MUL;
                    ctl1_next.kind = (lk == crau_pkg::KIND_COMPLEX ||
                                      rk == crau_pkg::KIND_COMPLEX) ?
                                     crau_pkg::KIND_COMPLEX : crau_pkg::KIND_REAL;
                end
            end
            crau_pkg::OP_NEG:
            begin
                if (!rnum)
                    ctl1_next.err = crau_pkg::ERR_KIND;
                else
                begin
                    ctl1_next.sel  = SEL_NEG;
                    ctl1_next.kind = rk;
                end
            end
            crau_pkg::OP_MULJ:
            begin
                if (!rnum)
                    ctl1_next.err = crau_pkg::ERR_KIND;
                else
                begin
                    ctl1_next.sel  = SEL_MULJ;
                    ctl1_next.kind = crau_pkg::KIND_COMPLEX;
                end
            end
            crau_pkg::OP_DIV:
            begin
                if (!(lnum && rnum))
                    ctl1_next.err = crau_pkg::ERR_KIND;
                else if (rk == crau_pkg::KIND_REAL)
                begin
                    if (c_in == '0)
                        ctl1_next.err = crau_pkg::ERR_DIV0;
                    else
                    begin
                        ctl1_next.sel  = SEL_DIVR;
                        ctl1_next.kind = lk;
                    end
                end
                else if (c_in == '0 && d_in == '0)
                    ctl1_next.err = crau_pkg::ERR_DIV0;
                else
                begin
                    ctl1_next.sel  = SEL_DIVC;
                    ctl1_next.kind = crau_pkg::KIND_COMPLEX;
                end
            end
            crau_pkg::OP_NOT:
            begin
                if (!rok)
                    ctl1_next.err = crau_pkg::ERR_KIND;
                else
                    ctl1_next.bval = !tr;
            end
            crau_pkg::OP_OR, crau_pkg::OP_AND:
            begin
                if (!(lok && rok))
                    ctl1_next.err = crau_pkg::ERR_KIND;
                else
                    ctl1_next.bval = (req.req_type == crau_pkg::OP_OR) ? (tl || tr) : (tl && tr);
            end
            crau_pkg::OP_EQ, crau_pkg::OP_NE:
            begin
                // equality only defined when a boolean is involved
                if (!(lok && rok) || !(lk == crau_pkg::KIND_BOOL || rk == crau_pkg::KIND_BOOL))
                    ctl1_next.err = crau_pkg::ERR_KIND;
                else
                    ctl1_next.bval = (tl == tr) ^ (req.req_type == crau_pkg::OP_NE);
            end
            crau_pkg::OP_GT, crau_pkg::OP_LT, crau_pkg::OP_GE, crau_pkg::OP_LE:
            begin
                if (lk == crau_pkg::KIND_COMPLEX || rk == crau_pkg::KIND_COMPLEX)
                    ctl1_next.err = crau_pkg::ERR_CPLX;
                else if (lk != crau_pkg::KIND_REAL || rk != crau_pkg::KIND_REAL)
                    ctl1_next.err = crau_pkg::ERR_KIND;
                else if (req.req_type == crau_pkg::OP_GT)
                    ctl1_next.bval = a_in > c_in;
                else if (req.req_type == crau_pkg::OP_LT)
                    ctl1_next.bval = a_in < c_in;
                else if (req.req_type == crau_pkg::OP_GE)
                    ctl1_next.bval = a_in >= c_in;
                else
                    ctl1_next.bval = a_in <= c_in;
            end
            default:
                ctl1_next.err = crau_pkg::ERR_KIND;
        endcase
    end

    // ---------------- stage 2: products and short sums ----------------
    logic signed [DW:0]   s_re_next, s_im_next;

    logic                 v2_reg;
    ctl_t                 ctl2_reg;
    logic signed [PW-1:0] ac2_reg, bd2_reg, ad2_reg, bc2_reg, cc2_reg, dd2_reg;
    logic signed [DW:0]   s_re2_reg, s_im2_reg;
    logic [DW-1:0]        ma2_reg, mb2_reg, mc2_reg;
    logic                 nre2_reg, nim2_reg;

    always_comb
    begin
        s_re_next = '0;
        s_im_next = '0;
        unique case (ctl1_reg.sel)
            SEL_ADD:
            begin
                s_re_next = {a1_reg[DW-1], a1_reg} + {c1_reg[DW-1], c1_reg};
                s_im_next = {b1_reg[DW-1], b1_reg} + {d1_reg[DW-1], d1_reg};
            end
            SEL_SUB:
            begin
                s_re_next = {a1_reg[DW-1], a1_reg} - {c1_reg[DW-1], c1_reg};
                s_im_next = {b1_reg[DW-1], b1_reg} - {d1_reg[DW-1], d1_reg};
            end
            SEL_NEG:
            begin
                s_re_next = -{c1_reg[DW-1], c1_reg};
                s_im_next = -{d1_reg[DW-1], d1_reg};
            end
            SEL_MULJ:
            begin
                s_re_next = -{d1_reg[DW-1], d1_reg};
                s_im_next = {c1_reg[DW-1], c1_reg};
            end
            default:
            begin
                s_re_next = '0;
                s_im_next = '0;
            end
        endcase
    end

    // ---------------- stage 3: wide sums ----------------
    logic signed [SW-1:0] dn_re_next, dn_im_next;

    logic                 v3_reg;
    ctl_t                 ctl3_reg;
    logic signed [SW-1:0] ms_re3_reg, ms_im3_reg;
    logic [PW-1:0]        dm_re3_reg, dm_im3_reg, den3_reg;
    logic                 dn_re3_reg, dn_im3_reg;
    logic signed [DW:0]   s_re3_reg, s_im3_reg;
    logic [DW-1:0]        ma3_reg, mb3_reg, mc3_reg;
    logic                 nre3_reg, nim3_reg;

    assign dn_re_next = SW'(ac2_reg) + SW'(bd2_reg);
    assign dn_im_next = SW'(bc2_reg) - SW'(ad2_reg);

    // ---------------- stage 4: finish short ops, feed divider ----------------
    line_t                line_in;
    logic signed [SW-1:0] fl_re, fl_im, fs_re, fs_im;
    logic [PW-1:0]        dv_num_re, dv_num_im, dv_den;
    logic                 dv_neg_re, dv_neg_im;

    logic                 dl_v_reg [DL];
    line_t                dl_reg   [DL];

    logic [DW-1:0]        q_re, q_im;
    logic                 ovf_re, ovf_im, qn_re, qn_im;

    // floor of the product sum, then clamp
    assign fl_re = ms_re3_reg >>> FB;
    assign fl_im = ms_im3_reg >>> FB;
    assign fs_re = SW'(s_re3_reg);
    assign fs_im = SW'(s_im3_reg);

    always_comb
    begin
        line_in.ctl = ctl3_reg;
        if (ctl3_reg.sel == SEL_MUL)
        begin
            line_in.re  = clamp(fl_re);
            line_in.im  = clamp(fl_im);
            line_in.sat = clipped(fl_re) || clipped(fl_im);
        end
        else
        begin
            line_in.re  = clamp(fs_re);
            line_in.im  = clamp(fs_im);
            line_in.sat = clipped(fs_re) || clipped(fs_im);
        end
    end

    always_comb
    begin
        if (ctl3_reg.sel == SEL_DIVC)
        begin
            dv_num_re = dm_re3_reg;
            dv_num_im = dm_im3_reg;
            dv_den    = den3_reg;
            dv_neg_re = dn_re3_reg;
            dv_neg_im = dn_im3_reg;
        end
        else
        begin
            dv_num_re = PW'(ma3_reg);
            dv_num_im = PW'(mb3_reg);
            dv_den    = PW'(mc3_reg);
            dv_neg_re = nre3_reg;
            dv_neg_im = nim3_reg;
        end
    end

    crau_div #(.DW(DW), .FB(FB)) u_div_re (
        .clk     (clk),
        .num     (dv_num_re),
        .den     (dv_den),
        .neg     (dv_neg_re),
        .q       (q_re),
        .ovf     (ovf_re),
        .neg_out (qn_re)
    );

    crau_div #(.DW(DW), .FB(FB)) u_div_im (
        .clk     (clk),
        .num     (dv_num_im),
        .den     (dv_den),
        .neg     (dv_neg_im),
        .q       (q_im),
        .ovf     (ovf_im),
        .neg_out (qn_im)
    );

    // ---------------- output stage ----------------
    line_t                lo;
    logic                 dsat_re, dsat_im;
    logic signed [DW-1:0] dq_re, dq_im;
    logic signed [DW-1:0] o_re, o_im;
    logic                 o_sat;
    crau_pkg::result_t    result_next;

    logic                 done_reg;
    crau_pkg::result_t    result_reg;

    assign lo      = dl_reg[DL-1];
    assign dsat_re = ovf_re || (qn_re ? (q_re[DW-1] && (q_re[DW-2:0] != '0)) : q_re[DW-1]);
    assign dsat_im = ovf_im || (qn_im ? (q_im[DW-1] && (q_im[DW-2:0] != '0)) : q_im[DW-1]);
    assign dq_re   = dsat_re ? (qn_re ? MINV : MAXV) : (qn_re ? -q_re : q_re);
    assign dq_im   = dsat_im ? (qn_im ? MINV : MAXV) : (qn_im ? -q_im : q_im);

    always_comb
    begin
        if (lo.ctl.sel == SEL_DIVR || lo.ctl.sel == SEL_DIVC)
        begin
            o_re  = dq_re;
            o_im  = dq_im;
            o_sat = dsat_re || dsat_im;
        end
        else
        begin
            o_re  = lo.re;
            o_im  = lo.im;
            o_sat = lo.sat;
        end

        result_next.error_code  = lo.ctl.err;
        result_next.result_kind = lo.ctl.kind;
        result_next.result_real = crau_pkg::FIELD_W'(o_re);
        result_next.result_imag = crau_pkg::FIELD_W'(o_im);
        result_next.saturated   = o_sat;
        if (lo.ctl.err != crau_pkg::ERR_NONE)
        begin
            result_next.result_kind = crau_pkg::KIND_REAL;
            result_next.result_real = '0;
            result_next.result_imag = '0;
            result_next.saturated   = 1'b0;
        end
        else if (lo.ctl.kind == crau_pkg::KIND_BOOL)
        begin
            result_next.result_real = crau_pkg::FIELD_W'(lo.ctl.bval);
            result_next.result_imag = '0;
            result_next.saturated   = 1'b0;
        end
        else if (lo.ctl.kind == crau_pkg::KIND_REAL)
            result_next.result_imag = '0;
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
            for (int i = 0; i < DL; i++)
                dl_v_reg[i] <= 1'b0;
        end
        else
        begin
            v1_reg      <= start && !busy;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            dl_v_reg[0] <= v3_reg;
            for (int i = 1; i < DL; i++)
                dl_v_reg[i] <= dl_v_reg[i-1];
            done_reg    <= dl_v_reg[DL-1];
        end
    end

    always_ff @(posedge clk)
    begin
        ctl1_reg <= ctl1_next;
        a1_reg   <= a_in;
        b1_reg   <= b_in;
        c1_reg   <= c_in;
        d1_reg   <= d_in;

        ctl2_reg  <= ctl1_reg;
        ac2_reg   <= a1_reg * c1_reg;
        bd2_reg   <= b1_reg * d1_reg;
        ad2_reg   <= a1_reg * d1_reg;
        bc2_reg   <= b1_reg * c1_reg;
        cc2_reg   <= c1_reg * c1_reg;
        dd2_reg   <= d1_reg * d1_reg;
        s_re2_reg <= s_re_next;
        s_im2_reg <= s_im_next;
        ma2_reg   <= mag(a1_reg);
        mb2_reg   <= mag(b1_reg);
        mc2_reg   <= mag(c1_reg);
        nre2_reg  <= a1_reg[DW-1] ^ c1_reg[DW-1];
        nim2_reg  <= b1_reg[DW-1] ^ c1_reg[DW-1];

        ctl3_reg   <= ctl2_reg;
        ms_re3_reg <= SW'(ac2_reg) - SW'(bd2_reg);
        ms_im3_reg <= SW'(ad2_reg) + SW'(bc2_reg);
        dm_re3_reg <= PW'(dn_re_next[SW-1] ? -dn_re_next : dn_re_next);
        dm_im3_reg <= PW'(dn_im_next[SW-1] ? -dn_im_next : dn_im_next);
        dn_re3_reg <= dn_re_next[SW-1];
        dn_im3_reg <= dn_im_next[SW-1];
        den3_reg   <= PW'(cc2_reg + dd2_reg);
        s_re3_reg  <= s_re2_reg;
        s_im3_reg  <= s_im2_reg;
        ma3_reg    <= ma2_reg;
        mb3_reg    <= mb2_reg;
        mc3_reg    <= mc2_reg;
        nre3_reg   <= nre2_reg;
        nim3_reg   <= nim2_reg;

        dl_reg[0] <= line_in;
        for (int i = 1; i < DL; i++)
            dl_reg[i] <= dl_reg[i-1];

        result_reg <= result_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    // ---------------- checks ----------------
    `CRAU_ASSERT_IMPL(a_fixed_latency, start && !busy, ##LAT done,
        "item did not complete after the fixed latency")
    `CRAU_ASSERT_IMPL(a_error_clears, done && result.error_code != crau_pkg::ERR_NONE,
        (result.result_kind == crau_pkg::KIND_REAL && result.result_real == '0 &&
         result.result_imag == '0 && !result.saturated),
        "error result carries data")
    `CRAU_ASSERT_IMPL(a_bool_form, done && result.result_kind == crau_pkg::KIND_BOOL,
        (result.result_real[crau_pkg::FIELD_W-1:1] == '0 && result.result_imag == '0 &&
         !result.saturated),
        "boolean result not 0 or 1")

endmodule

// ===== sim/complex_real_arithmetic_unit_core_test.sv =====
// self-checking testbench for complex_real_arithmetic_unit_core
// depends on crau_pkg and the core rtl; a built-in predictor computes every expected result
module complex_real_arithmetic_unit_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] wide_t;

    class result_scoreboard;
        crau_pkg::result_t pending[$];
        int mismatches;
        int checked;
        int accepted;

        function logic signed [31:0] clamp(wide_t v, inout bit sat);
            if (v > wide_t'(32'sh7fffffff))
            begin
                sat = 1;
                return 32'sh7fffffff;
            end
            if (v < -wide_t'(64'sh80000000))
            begin
                sat = 1;
                return 32'sh80000000;
            end
            return v[31:0];
        endfunction

        function bit truthy(logic [1:0] k, wide_t re, wide_t im);
            return (k == crau_pkg::KIND_COMPLEX) ? (re != 0 || im != 0) : (re != 0);
        endfunction

        function crau_pkg::result_t compute(crau_pkg::req_t r);
            wide_t a, b, c, d, den, lo, hi;
            bit lnum, rnum, lok, rok, sat, bv;
            logic [1:0] kind, err;
            logic signed [31:0] re, im;
            crau_pkg::result_t res;
            a = $signed(r.left_re);
            b = $signed(r.left_im);
            c = $signed(r.right_real);
            d = $signed(r.right_imag);
            if (r.left_kind != crau_pkg::KIND_COMPLEX) b = 0;
            if (r.right_kind != crau_pkg::KIND_COMPLEX) d = 0;
            lnum = r.left_kind <= crau_pkg::KIND_COMPLEX;
            rnum = r.right_kind <= crau_pkg::KIND_COMPLEX;
            lok = r.left_kind <= crau_pkg::KIND_BOOL;
            rok = r.right_kind <= crau_pkg::KIND_BOOL;
            sat = 0; bv = 0; kind = crau_pkg::KIND_REAL; err = crau_pkg::ERR_NONE;
            re = 0; im = 0;
            case (r.req_type)
                crau_pkg::OP_ADD, crau_pkg::OP_SUB:
                begin
                    if (!(lnum && rnum)) err = crau_pkg::ERR_KIND;
                    else
                    begin
                        kind = (r.left_kind | r.right_kind) & crau_pkg::KIND_COMPLEX;
                        re = clamp(r.req_type == crau_pkg::OP_ADD ? a + c : a - c, sat);
                        im = clamp(r.req_type == crau_pkg::OP_ADD ? b + d : b - d, sat);
                    end
                end
                crau_pkg::OP_NEG:
                begin
                    if (!rnum) err = crau_pkg::ERR_KIND;
                    else
                    begin
                        kind = r.right_kind;
                        re = clamp(-c, sat);
                        im = clamp(-d, sat);
                    end
                end
                crau_pkg::OP_MUL:
                begin
                    if (!(lnum && rnum)) err = crau_pkg::ERR_KIND;
                    else
                    begin
                        kind = (r.left_kind | r.right_kind) & crau_pkg::KIND_COMPLEX;
                        // product rounds toward minus infinity
                        re = clamp((a * c - b * d) >>> 16, sat);
                        im = clamp((a * d + b * c) >>> 16, sat);
                    end
                end
                crau_pkg::OP_MULJ:
                begin
                    if (!rnum) err = crau_pkg::ERR_KIND;
                    else
                    begin
                        kind = crau_pkg::KIND_COMPLEX;
                        re = clamp(-d, sat);
                        im = clamp(c, sat);
                    end
                end
                crau_pkg::OP_DIV:
                begin
                    if (!(lnum && rnum)) err = crau_pkg::ERR_KIND;
                    else if (r.right_kind == crau_pkg::KIND_REAL)
                    begin
                        if (c == 0) err = crau_pkg::ERR_DIV0;
                        else
                        begin
                            kind = r.left_kind;
                            // signed division truncates toward zero
                            re = clamp((a <<< 16) / c, sat);
                            im = clamp((b <<< 16) / c, sat);
                        end
                    end
                    else
                    begin
                        den = c * c + d * d;
                        if (den == 0) err = crau_pkg::ERR_DIV0;
                        else
                        begin
                            kind = crau_pkg::KIND_COMPLEX;
                            lo = (a * c + b * d) <<< 16;
                            hi = (b * c - a * d) <<< 16;
                            re = clamp(lo / den, sat);
                            im = clamp(hi / den, sat);
                        end
                    end
                end
                crau_pkg::OP_NOT:
                begin
                    if (!rok) err = crau_pkg::ERR_KIND;
                    else
                    begin
                        kind = crau_pkg::KIND_BOOL;
                        bv = !truthy(r.right_kind, c, d);
                    end
                end
                crau_pkg::OP_OR, crau_pkg::OP_AND:
                begin
                    if (!(lok && rok)) err = crau_pkg::ERR_KIND;
                    else
                    begin
                        kind = crau_pkg::KIND_BOOL;
                        if (r.req_type == crau_pkg::OP_OR)
                            bv = truthy(r.left_kind, a, b) || truthy(r.right_kind, c, d);
                        else
                            bv = truthy(r.left_kind, a, b) && truthy(r.right_kind, c, d);
                    end
                end
                crau_pkg::OP_EQ, crau_pkg::OP_NE:
                begin
                    if (!(lok && rok) || !(r.left_kind == crau_pkg::KIND_BOOL ||
                                           r.right_kind == crau_pkg::KIND_BOOL))
                        err = crau_pkg::ERR_KIND;
                    else
                    begin
                        kind = crau_pkg::KIND_BOOL;
                        bv = truthy(r.left_kind, a, b) == truthy(r.right_kind, c, d);
                        if (r.req_type == crau_pkg::OP_NE) bv = !bv;
                    end
                end
                crau_pkg::OP_GT, crau_pkg::OP_LT, crau_pkg::OP_GE, crau_pkg::OP_LE:
                begin
                    if (r.left_kind == crau_pkg::KIND_COMPLEX ||
                        r.right_kind == crau_pkg::KIND_COMPLEX)
                        err = crau_pkg::ERR_CPLX;
                    else if (r.left_kind != crau_pkg::KIND_REAL ||
                             r.right_kind != crau_pkg::KIND_REAL)
                        err = crau_pkg::ERR_KIND;
                    else
                    begin
                        kind = crau_pkg::KIND_BOOL;
                        case (r.req_type)
                            crau_pkg::OP_GT: bv = a > c;
                            crau_pkg::OP_LT: bv = a < c;
                            crau_pkg::OP_GE: bv = a >= c;
                            default: bv = a <= c;
                        endcase
                    end
                end
                default: err = crau_pkg::ERR_KIND;
            endcase
            if (err != crau_pkg::ERR_NONE)
            begin
                kind = crau_pkg::KIND_REAL; re = 0; im = 0; sat = 0;
            end
            else if (kind == crau_pkg::KIND_BOOL)
            begin
                re = bv ? 32'sd1 : 32'sd0;
                im = 0;
            end
            else if (kind == crau_pkg::KIND_REAL) im = 0;
            res.result_kind = kind;
            res.result_real = re;
            res.result_imag = im;
            res.error_code = err;
            res.saturated = sat;
            return res;
        endfunction

        function void note(crau_pkg::req_t r);
            pending.push_back(compute(r));
            accepted++;
        endfunction

        function void check(crau_pkg::result_t got);
            crau_pkg::result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.result_kind !== want.result_kind ||
                got.result_real !== want.result_real ||
                got.result_imag !== want.result_imag || got.error_code !== want.error_code ||
                got.saturated !== want.saturated)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch #%0d: kind %0d/%0d re %h/%h im %h/%h err %0d/%0d sat %0d/%0d",
                             checked, want.result_kind, got.result_kind, want.result_real,
                             got.result_real, want.result_imag, got.result_imag,
                             want.error_code, got.error_code, want.saturated, got.saturated);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy;
    logic done;
    crau_pkg::req_t req = '0;
    crau_pkg::result_t result;
    result_scoreboard board = new();
    bit idle_on = 1;

    complex_real_arithmetic_unit_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req(req), .done(done), .result(result)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy) board.note(req);
            if (done) board.check(result);
        end
    end

    initial
    begin
        #1ms;
        $display("FAIL complex_real_arithmetic_unit_core");
        $finish;
    end

    task automatic send(crau_pkg::req_t r);
        @(negedge clk);
        while (idle_on && $urandom_range(0, 99) < 23)
        begin
            start = 0;
            @(negedge clk);
        end
        start = 1;
        req = r;
        do @(posedge clk); while (busy);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'($signed($urandom_range(0, 6)) - 3) <<< 16;
            3: return 32'($signed($urandom_range(0, 8)) - 4);
            default: return $urandom;
        endcase
    endfunction

    function automatic crau_pkg::req_t random_req();
        crau_pkg::req_t r;
        r.req_type = 4'($urandom_range(0, 15));
        r.left_kind = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        r.right_kind = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        r.left_re = pick_value();
        r.left_im = pick_value();
        r.right_real = pick_value();
        r.right_imag = pick_value();
        return r;
    endfunction

    function automatic crau_pkg::req_t mk(logic [3:0] op, logic [1:0] lk, logic [31:0] lr,
                                          logic [31:0] li, logic [1:0] rk, logic [31:0] rr,
                                          logic [31:0] ri);
        crau_pkg::req_t r;
        r.req_type = op; r.left_kind = lk; r.left_re = lr; r.left_im = li;
        r.right_kind = rk; r.right_real = rr; r.right_imag = ri;
        return r;
    endfunction

    initial
    begin
        int wait_cycles;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        // extremes, each opcode and the error cases
        send(mk(crau_pkg::OP_ADD, crau_pkg::KIND_REAL, 32'h7fffffff, 0,
                crau_pkg::KIND_REAL, 32'h7fffffff, 0));
        send(mk(crau_pkg::OP_SUB, crau_pkg::KIND_COMPLEX, 32'h80000000, 32'h7fffffff,
                crau_pkg::KIND_REAL, 32'h7fffffff, 32'h1234));
        send(mk(crau_pkg::OP_NEG, crau_pkg::KIND_REAL, 5, 5,
                crau_pkg::KIND_COMPLEX, 32'h80000000, 32'h80000000));
        send(mk(crau_pkg::OP_MUL, crau_pkg::KIND_COMPLEX, 32'h80000000, 32'h80000000,
                crau_pkg::KIND_COMPLEX, 32'h80000000, 32'h7fffffff));
        send(mk(crau_pkg::OP_MUL, crau_pkg::KIND_REAL, 32'hffffffff, 0,
                crau_pkg::KIND_REAL, 32'h00000001, 0));
        send(mk(crau_pkg::OP_MULJ, crau_pkg::KIND_BOOL, 1, 0,
                crau_pkg::KIND_COMPLEX, 32'h00010000, 32'h80000000));
        send(mk(crau_pkg::OP_DIV, crau_pkg::KIND_REAL, 32'h00010000, 0,
                crau_pkg::KIND_REAL, 0, 32'h5));
        send(mk(crau_pkg::OP_DIV, crau_pkg::KIND_COMPLEX, 32'h00010000, 3,
                crau_pkg::KIND_COMPLEX, 0, 0));
        send(mk(crau_pkg::OP_DIV, crau_pkg::KIND_COMPLEX, 32'h00030000, 32'hfffe0000,
                crau_pkg::KIND_COMPLEX, 32'h00010000, 32'h00020000));
        send(mk(crau_pkg::OP_DIV, crau_pkg::KIND_REAL, 32'h80000000, 0,
                crau_pkg::KIND_REAL, 32'hffffffff, 0));
        send(mk(crau_pkg::OP_NOT, crau_pkg::KIND_REAL, 0, 0, crau_pkg::KIND_COMPLEX, 0, 1));
        send(mk(crau_pkg::OP_OR, crau_pkg::KIND_BOOL, 0, 0, crau_pkg::KIND_REAL, 0, 7));
        send(mk(crau_pkg::OP_AND, crau_pkg::KIND_COMPLEX, 0, 9, crau_pkg::KIND_BOOL, 4, 0));
        send(mk(crau_pkg::OP_EQ, crau_pkg::KIND_BOOL, 1, 0,
                crau_pkg::KIND_REAL, 32'h00020000, 0));
        send(mk(crau_pkg::OP_EQ, crau_pkg::KIND_REAL, 1, 0, crau_pkg::KIND_REAL, 1, 0));
        send(mk(crau_pkg::OP_NE, crau_pkg::KIND_COMPLEX, 0, 0, crau_pkg::KIND_BOOL, 1, 0));
        send(mk(crau_pkg::OP_GT, crau_pkg::KIND_BOOL, 1, 0, crau_pkg::KIND_COMPLEX, 1, 1));
        send(mk(crau_pkg::OP_LT, crau_pkg::KIND_REAL, 32'h80000000, 0,
                crau_pkg::KIND_REAL, 32'h7fffffff, 0));
        send(mk(crau_pkg::OP_GE, crau_pkg::KIND_REAL, 3, 0, crau_pkg::KIND_REAL, 3, 0));
        send(mk(crau_pkg::OP_LE, crau_pkg::KIND_REAL, 3, 0, crau_pkg::KIND_BOOL, 3, 0));
        send(mk(4'd15, crau_pkg::KIND_REAL, 1, 0, crau_pkg::KIND_REAL, 1, 0));
        send(mk(crau_pkg::OP_ADD, 2'd3, 1, 0, crau_pkg::KIND_REAL, 1, 0));
        for (int n = 0; n < 800; n++)
        begin
            // one long run with no gaps
            idle_on = !(n >= 300 && n < 450);
            send(random_req());
        end
        @(negedge clk);
        start = 0;
        wait_cycles = 0;
        while (board.pending.size() != 0 && wait_cycles < 1000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (45) @(posedge clk);
        $display("ran %0d items through all opcodes and operand kinds, %0d results checked",
                 board.accepted, board.checked);
        $display("%0d mismatches, %0d results still awaited",
                 board.mismatches, board.pending.size());
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("PASS complex_real_arithmetic_unit_core");
        else
            $display("FAIL complex_real_arithmetic_unit_core");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+design
design/crau_pkg.sv
design/crau_div.sv
design/complex_real_arithmetic_unit_core.sv
sim/complex_real_arithmetic_unit_core_test.sv
